[hw/rtl/cra_pkg.sv]
`timescale 1ns / 1ps

package cra_pkg;

  localparam int WINDOW_DEF = 8;

  localparam int CFG_W       = 16;
  localparam int SAMPLE_W    = 12;
  localparam int RAW_W       = 16;
  localparam int PROD_W      = 32;
  localparam int DIVISOR_W   = 12;
  localparam int DIV_CNT_W   = 6;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 4;

  localparam logic [RAW_W-1:0]  RAW_INVALID = 16'hFFFF;
  localparam logic [PROD_W-1:0] AVG_LIMIT   = 32'd2048;

  localparam logic [1:0] REG_CALIBRATION = 2'd0;
  localparam logic [1:0] REG_SERIES      = 2'd1;
  localparam logic [1:0] REG_CAP_OFFSET  = 2'd2;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] count;
  } div_req_t;

endpackage

[hw/rtl/cra_cell.sv]
`timescale 1ns / 1ps

module cra_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        shift_en,
  input  logic [cra_pkg::RAW_W-1:0]   d,
  output logic [cra_pkg::RAW_W-1:0]   q
);

  logic [cra_pkg::RAW_W-1:0] val_r;
  logic [cra_pkg::RAW_W-1:0] val_nxt;

  always_comb begin
    val_nxt = shift_en ? d : val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign q = val_r;

endmodule

[hw/rtl/cra_div.sv]
`timescale 1ns / 1ps

module cra_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cra_pkg::div_req_t               req,
  input  logic [cra_pkg::PROD_W-1:0]      dividend,
  input  logic [cra_pkg::DIVISOR_W-1:0]   divisor,
  output logic [cra_pkg::PROD_W-1:0]      quotient,
  output logic                            busy
);

  logic [cra_pkg::PROD_W-1:0]    q_r;
  logic [cra_pkg::PROD_W-1:0]    q_nxt;
  logic [cra_pkg::DIVISOR_W:0]   rem_r;
  logic [cra_pkg::DIVISOR_W:0]   rem_nxt;
  logic [cra_pkg::DIVISOR_W-1:0] dvs_r;
  logic [cra_pkg::DIVISOR_W-1:0] dvs_nxt;
  logic [cra_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [cra_pkg::DIV_CNT_W-1:0] cnt_nxt;
  logic                          busy_r;
  logic                          busy_nxt;
  logic [cra_pkg::DIVISOR_W:0]   rem_sh;
  logic                          ge;

  always_comb begin
    rem_sh   = {rem_r[cra_pkg::DIVISOR_W-1:0], q_r[cra_pkg::PROD_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = req.count;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[cra_pkg::PROD_W-2:0], ge};
      rem_nxt = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      cnt_nxt = cnt_r - cra_pkg::DIV_CNT_W'(1);
      if (cnt_r == cra_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = q_r;
  assign busy     = busy_r;

endmodule

[hw/rtl/conductivity_resistance_averager.sv]
`timescale 1ns / 1ps
// An accepted request passes the multiply, divide-start, divide, raw, shift, average and output
// states, the divide being the 32-step bit-serial divider for the resistance; a zero sample or
// zero calibration skips it. The mean comes from a multiplication by the reciprocal of the window.
// One request is in flight at a time, and the next is taken only once the last result has gone to
// the output register, which holds off while an earlier result waits for the receiver. Reset is
// synchronous, active-low; clears control and config registers, sample cells and running sum.
module conductivity_resistance_averager #(
  parameter int WINDOW = cra_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cra_pkg::SAMPLE_W-1:0]      in_adc_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cra_pkg::RAW_W-1:0]         out_averaged_resistance,
  output logic                              out_invalid,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cra_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [cra_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [cra_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int SUM_W      = cra_pkg::RAW_W + $clog2(WINDOW);
  localparam int RECIP_SH   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W    = SUM_W + 1;
  localparam int AVG_PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL     = 3'd1;
  localparam logic [2:0] S_DSTART  = 3'd2;
  localparam logic [2:0] S_DIV     = 3'd3;
  localparam logic [2:0] S_RAW     = 3'd4;
  localparam logic [2:0] S_SHIFT   = 3'd5;
  localparam logic [2:0] S_AVG     = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [cra_pkg::CFG_W-1:0] cal_r;
  logic [cra_pkg::CFG_W-1:0] ser_r;
  logic [cra_pkg::CFG_W-1:0] cap_r;
  logic                      cfg_wr;
  logic [1:0]                cfg_idx;

  logic [2:0]                    state_r;
  logic [2:0]                    state_nxt;
  logic [cra_pkg::SAMPLE_W-1:0]  sample_r;
  logic [cra_pkg::SAMPLE_W-1:0]  sample_nxt;
  logic [cra_pkg::PROD_W-1:0]    prod_r;
  logic [cra_pkg::PROD_W-1:0]    prod_nxt;
  logic [cra_pkg::RAW_W-1:0]     raw_r;
  logic [cra_pkg::RAW_W-1:0]     raw_nxt;
  logic [SUM_W-1:0]              sum_r;
  logic [SUM_W-1:0]              sum_nxt;
  logic [cra_pkg::RAW_W-1:0]     avg_r;
  logic [cra_pkg::RAW_W-1:0]     avg_nxt;
  logic [AVG_PROD_W-1:0]         avg_prod;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [cra_pkg::RAW_W-1:0]     out_avg_r;
  logic [cra_pkg::RAW_W-1:0]     out_avg_nxt;
  logic                          out_inv_r;
  logic                          out_inv_nxt;

  cra_pkg::div_req_t             div_req;
  logic [cra_pkg::PROD_W-1:0]    div_dividend;
  logic [cra_pkg::DIVISOR_W-1:0] div_divisor;
  logic [cra_pkg::PROD_W-1:0]    div_quot;
  logic                          div_busy;

  logic                          shift_en;
  logic [cra_pkg::RAW_W-1:0]     chain [WINDOW+1];

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      cra_pkg::REG_CALIBRATION: cfg_prdata = {16'd0, cal_r};
      cra_pkg::REG_SERIES:      cfg_prdata = {16'd0, ser_r};
      cra_pkg::REG_CAP_OFFSET:  cfg_prdata = {16'd0, cap_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
      ser_r <= '0;
      cap_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cra_pkg::REG_CALIBRATION: cal_r <= cfg_pwdata[cra_pkg::CFG_W-1:0];
        cra_pkg::REG_SERIES:      ser_r <= cfg_pwdata[cra_pkg::CFG_W-1:0];
        cra_pkg::REG_CAP_OFFSET:  cap_r <= cfg_pwdata[cra_pkg::CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The oldest value leaves the last cell as the new one enters the first.
  assign chain[0] = raw_r;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    cra_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (chain[i]),
      .q        (chain[i+1])
    );
  end

  cra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .busy     (div_busy)
  );

  assign in_ready = (state_r == S_IDLE);
  assign shift_en = (state_r == S_SHIFT);

  assign avg_prod = AVG_PROD_W'(sum_r) * AVG_PROD_W'(RECIP);

  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    prod_nxt      = prod_r;
    raw_nxt       = raw_r;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_avg_nxt   = out_avg_r;
    out_inv_nxt   = out_inv_r;
    div_req.start = 1'b0;
    div_req.count = cra_pkg::DIV_CNT_W'(cra_pkg::PROD_W);
    div_dividend  = prod_r;
    div_divisor   = sample_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_adc_sample;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt = cra_pkg::PROD_W'(ser_r) * cra_pkg::PROD_W'(cal_r);
        if (cal_r == '0 || sample_r == '0) begin
          raw_nxt   = cra_pkg::RAW_INVALID;
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) begin
          state_nxt = S_RAW;
        end
      end
      S_RAW: begin
        raw_nxt   = div_quot[cra_pkg::RAW_W-1:0]
                    - ({ser_r[cra_pkg::RAW_W-2:0], 1'b0} + cap_r);
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        sum_nxt   = sum_r + SUM_W'(raw_r) - SUM_W'(chain[WINDOW]);
        state_nxt = S_AVG;
      end
      S_AVG: begin
        avg_nxt   = avg_prod[RECIP_SH +: cra_pkg::RAW_W];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (cra_pkg::PROD_W'(avg_r) > cra_pkg::AVG_LIMIT) begin
            out_avg_nxt = cra_pkg::RAW_INVALID;
            out_inv_nxt = 1'b1;
          end else begin
            out_avg_nxt = avg_r;
            out_inv_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r  <= sample_nxt;
    prod_r    <= prod_nxt;
    raw_r     <= raw_nxt;
    avg_r     <= avg_nxt;
    out_avg_r <= out_avg_nxt;
    out_inv_r <= out_inv_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_averaged_resistance = out_avg_r;
  assign out_invalid             = out_inv_r;

endmodule

[dv/resistance_checker.sv]
`timescale 1ns / 1ps

module resistance_checker
  import cra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_adc_sample,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [RAW_W-1:0]      out_averaged_resistance,
  input  logic                  out_invalid,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    fail_count,
  output int                    pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [RAW_W-1:0] mean;
    logic             invalid;
  } mean_t;

  mean_t            expected_means[$];
  logic [CFG_W-1:0] cal_reg;
  logic [CFG_W-1:0] series_reg;
  logic [CFG_W-1:0] offset_reg;
  logic [RAW_W-1:0] ring [WINDOW_DEF];
  int unsigned      slot;

  function automatic logic [RAW_W-1:0] resistance_of(input logic [SAMPLE_W-1:0] s);
    logic [PROD_W-1:0] quotient;
    logic [PROD_W-1:0] diff;
    if (cal_reg == '0 || s == '0) begin
      return RAW_INVALID;
    end
    quotient = (PROD_W'(series_reg) * PROD_W'(cal_reg)) / PROD_W'(s);
    diff = quotient - (2 * PROD_W'(series_reg) + PROD_W'(offset_reg));
    return diff[RAW_W-1:0];
  endfunction

  function automatic mean_t store_and_average(input logic [SAMPLE_W-1:0] s);
    logic [PROD_W-1:0] total;
    mean_t             m;
    ring[slot] = resistance_of(s);
    slot = (slot + 1) % WINDOW_DEF;
    total = '0;
    for (int k = 0; k < WINDOW_DEF; k++) begin
      total = total + PROD_W'(ring[k]);
    end
    total = total / WINDOW_DEF;
    if (total > AVG_LIMIT) begin
      m.mean = RAW_INVALID;
      m.invalid = 1'b1;
    end else begin
      m.mean = total[RAW_W-1:0];
      m.invalid = 1'b0;
    end
    return m;
  endfunction

  task automatic note_mismatch(input string what, input mean_t want, input mean_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected mean %0d invalid %0b, got mean %0d invalid %0b",
               $realtime, what, want.mean, want.invalid, got.mean, got.invalid);
    end
  endtask

  always @(posedge clk) begin
    mean_t got;
    mean_t want;
    if (!rst_n) begin
      cal_reg = '0;
      series_reg = '0;
      offset_reg = '0;
      for (int k = 0; k < WINDOW_DEF; k++) begin
        ring[k] = '0;
      end
      slot = 0;
      expected_means.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[APB_ADDR_W-1:2])
          REG_CALIBRATION: cal_reg = cfg_pwdata[CFG_W-1:0];
          REG_SERIES:      series_reg = cfg_pwdata[CFG_W-1:0];
          REG_CAP_OFFSET:  offset_reg = cfg_pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.mean = out_averaged_resistance;
        got.invalid = out_invalid;
        if (expected_means.size() == 0) begin
          note_mismatch("result with no request outstanding", '0, got);
        end else begin
          want = expected_means.pop_front();
          if (got.mean !== want.mean || got.invalid !== want.invalid) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_means.push_back(store_and_average(in_adc_sample));
      end
    end
    pending = expected_means.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import cra_pkg::*;

  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam int         CLK_HALF    = 4;
  localparam int         SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
  localparam int         PHASES      = 6;
  localparam int         PHASE_ITEMS = 222;
  localparam int         SETTLE      = 64;
  localparam int         HOLD_AT     = 1000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         STALL_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic [SAMPLE_W-1:0]   in_adc_sample = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;

  logic                  in_ready;
  logic                  out_valid;
  logic [RAW_W-1:0]      out_averaged_resistance;
  logic                  out_invalid;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int                    fail_count;
  int                    pending;
  int unsigned           in_count = 0;
  int unsigned           out_count = 0;
  int unsigned           stall_cycles = 0;
  int unsigned           sender_idle_pct = 0;
  int unsigned           receiver_idle_pct = 0;
  int unsigned           hold_left = 0;
  bit                    hold_done = 1'b0;
  logic [CFG_W-1:0]      cal_set = '0;
  logic [CFG_W-1:0]      series_set = '0;
  logic [CFG_W-1:0]      offset_set = '0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  conductivity_resistance_averager uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_adc_sample           (in_adc_sample),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_averaged_resistance (out_averaged_resistance),
    .out_invalid             (out_invalid),
    .cfg_psel                (cfg_psel),
    .cfg_penable             (cfg_penable),
    .cfg_pwrite              (cfg_pwrite),
    .cfg_paddr               (cfg_paddr),
    .cfg_pwdata              (cfg_pwdata),
    .cfg_prdata              (cfg_prdata),
    .cfg_pready              (cfg_pready)
  );

  resistance_checker u_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_adc_sample           (in_adc_sample),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_averaged_resistance (out_averaged_resistance),
    .out_invalid             (out_invalid),
    .cfg_psel                (cfg_psel),
    .cfg_penable             (cfg_penable),
    .cfg_pwrite              (cfg_pwrite),
    .cfg_paddr               (cfg_paddr),
    .cfg_pwdata              (cfg_pwdata),
    .cfg_pready              (cfg_pready),
    .fail_count              (fail_count),
    .pending                 (pending)
  );

  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_count <= in_count + 1;
    end
    if (out_valid && out_ready) begin
      out_count <= out_count + 1;
    end
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // The long hold-off lets the block fill up while requests keep being offered.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && out_count >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned target;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_adc_sample <= s;
    target = in_count + 1;
    do @(negedge clk); while (in_count != target);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= {16'($urandom()), value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (index)
      REG_CALIBRATION: cal_set = value;
      REG_SERIES:      series_set = value;
      REG_CAP_OFFSET:  offset_set = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_W-1:0] cal, input logic [CFG_W-1:0] series,
                           input logic [CFG_W-1:0] offset);
    write_reg(REG_CALIBRATION, cal);
    write_reg(REG_SERIES, series);
    write_reg(REG_CAP_OFFSET, offset);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Picks a reading giving a raw resistance near the goal under current settings, else a random one.
  function automatic logic [SAMPLE_W-1:0] sample_for_target(input int unsigned goal);
    longint den;
    longint s;
    den = longint'(goal) + 2 * longint'(series_set) + longint'(offset_set);
    s = (den == 0) ? 0 : (longint'(series_set) * longint'(cal_set)) / den;
    if (s == 0 || s > SAMPLE_MAX) begin
      return SAMPLE_W'($urandom_range(1, SAMPLE_MAX));
    end
    return SAMPLE_W'(s);
  endfunction

  initial begin
    logic [SAMPLE_W-1:0] corner_samples[6];
    corner_samples = '{'0, SAMPLE_W'(1), SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(2048),
                       SAMPLE_W'('hAAA), SAMPLE_W'('h555)};
    sender_idle_pct = 22;
    receiver_idle_pct = 52;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_sample('0);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    drain();
    configure(16'd4000, 16'd1000, 16'd100);
    foreach (corner_samples[i]) begin
      send_sample(corner_samples[i]);
    end
    repeat (WINDOW_DEF) send_sample(sample_for_target(0));
    repeat (WINDOW_DEF) send_sample(sample_for_target(int'(AVG_LIMIT)));

    for (int p = 0; p < PHASES; p++) begin
      int unsigned sent;
      int unsigned burst;
      bit          banded;
      if (p < 2) begin
        sender_idle_pct = 22;
        receiver_idle_pct = 52;
      end else if (p < 4) begin
        sender_idle_pct = 52;
        receiver_idle_pct = 22;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      drain();
      case (p)
        0: configure(16'd4000, 16'd1000, 16'd300);
        1: configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: configure(16'd1, 16'd0, 16'd0);
        3: configure(16'($urandom()), 16'($urandom()), 16'($urandom()));
        4: configure(16'd0, 16'd500, 16'd20);
        default: begin
          write_reg(REG_SPARE, 16'($urandom()));
          configure(16'd2500, 16'd1500, 16'd50);
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(8, 24);
        banded = ($urandom_range(0, 9) < 7);
        repeat (burst) begin
          if (banded) begin
            send_sample(sample_for_target($urandom_range(0, int'(AVG_LIMIT) + 64)));
          end else if ($urandom_range(0, 7) == 0) begin
            send_sample('0);
          end else begin
            send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
          end
        end
        sent += burst;
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/cra_pkg.sv
hw/rtl/cra_cell.sv
hw/rtl/cra_div.sv
hw/rtl/conductivity_resistance_averager.sv
dv/resistance_checker.sv
dv/tb.sv
